>>> design/vagd_pkg.sv
// Shared types, widths and filter coefficients for the VAG ADPCM frame decoder.
`timescale 1ns / 1ps

package vagd_pkg;

    localparam int CH_W    = 1;
    localparam int POS_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int PCM_W   = 16;
    localparam int HIST_W  = 32;
    localparam int SHIFT_W = 4;
    localparam int FILT_W  = 3;
    localparam int COEF_W  = 8;
    localparam int PRM_W   = SHIFT_W + FILT_W;

    localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
    localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;

    localparam logic [NIB_W-1:0] FILTER_MAX = 4'd4;

    typedef logic signed [HIST_W-1:0] t_hist;
    typedef logic signed [PCM_W-1:0]  t_pcm;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_ONE   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_TWO   = 3'd2;
    localparam logic [FILT_W-1:0] FILT_THREE = 3'd3;
    localparam logic [FILT_W-1:0] FILT_FOUR  = 3'd4;

    // Operands for one nibble through the predictor.
    typedef struct packed {
        t_hist              p1;
        t_hist              p2;
        logic [SHIFT_W-1:0] shift;
        logic [FILT_W-1:0]  filter;
        logic [NIB_W-1:0]   nibble;
    } t_alu_req;

    typedef struct packed {
        t_hist sum;
        t_pcm  pcm;
    } t_alu_rsp;

    function automatic t_coef coef_k0(input logic [FILT_W-1:0] f);
        t_coef k;
        unique case (f)
            FILT_NONE:  k = 8'sd0;
            FILT_ONE:   k = 8'sd60;
            FILT_TWO:   k = 8'sd115;
            FILT_THREE: k = 8'sd98;
            FILT_FOUR:  k = 8'sd122;
            default:    k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic t_coef coef_k1(input logic [FILT_W-1:0] f);
        t_coef k;
        unique case (f)
            FILT_NONE:  k = 8'sd0;
            FILT_ONE:   k = 8'sd0;
            FILT_TWO:   k = -8'sd52;
            FILT_THREE: k = -8'sd55;
            FILT_FOUR:  k = -8'sd60;
            default:    k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

>>> design/vagd_predictor.sv
// Nibble scaling, second-order prediction, history wrap and 16-bit saturation.
`timescale 1ns / 1ps

module vagd_predictor (
    input  vagd_pkg::t_alu_req i_req,
    output vagd_pkg::t_alu_rsp o_rsp
);
    import vagd_pkg::*;

    t_coef                           k0;
    t_coef                           k1;
    logic signed [HIST_W+COEF_W-1:0] prod0;
    logic signed [HIST_W+COEF_W-1:0] prod1;
    logic signed [HIST_W+COEF_W:0]   pred_sum;
    logic signed [HIST_W+COEF_W:0]   pred_adj;
    logic signed [HIST_W+COEF_W:0]   pred_q;
    logic signed [PCM_W-1:0]         scaled_base;
    logic signed [PCM_W-1:0]         scaled;
    t_hist                           sum;
    logic                            sat_hi;
    logic                            sat_lo;

    assign k0 = coef_k0(i_req.filter);
    assign k1 = coef_k1(i_req.filter);

    assign prod0    = i_req.p1 * k0;
    assign prod1    = i_req.p2 * k1;
    assign pred_sum = prod0 + prod1;
    // Bias negative sums so the divide by 64 truncates toward zero.
    assign pred_adj = pred_sum + (pred_sum[HIST_W+COEF_W] ? 41'sd63 : 41'sd0);
    assign pred_q   = pred_adj >>> 6;

    assign scaled_base = {i_req.nibble, 12'h000};
    assign scaled      = scaled_base >>> i_req.shift;

    // Wrap to 32 bits: low bits of the sum only depend on low bits of the terms.
    assign sum = pred_q[HIST_W-1:0] + {{(HIST_W-PCM_W){scaled[PCM_W-1]}}, scaled};

    assign sat_hi = !sum[HIST_W-1] && (|sum[HIST_W-2:PCM_W-1]);
    assign sat_lo = sum[HIST_W-1] && !(&sum[HIST_W-2:PCM_W-1]);

    always_comb begin
        o_rsp.sum = sum;
        if (sat_hi) begin
            o_rsp.pcm = 16'sh7FFF;
        end else if (sat_lo) begin
            o_rsp.pcm = -16'sh8000;
        end else begin
            o_rsp.pcm = sum[PCM_W-1:0];
        end
    end

endmodule

>>> design/vag_adpcm_frame_decoder_unit.sv
// Top level: per-channel state memories, byte sequencer and output register.
`timescale 1ns / 1ps

// Each accepted byte is registered in the read stage; a header updates state as it
//   leaves. A sample byte moves on to the execute stage, whose low-nibble, then
//   high-nibble sample is registered for output. The next sample byte waits until
//   the previous byte's two samples, sharing one predictor and write-back, are done.
// Flag bytes and bytes for channels at or above CHANNEL_COUNT are dropped on accept.
// Reset: synchronous, active low; clears per-entry valid bits so all history, shift
//   and filter read as zero. No clearing pass.
module vag_adpcm_frame_decoder_unit #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [vagd_pkg::CH_W-1:0]    i_channel,
    input  logic [vagd_pkg::POS_W-1:0]   i_byte_position,
    input  logic [vagd_pkg::BYTE_W-1:0]  i_byte_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [vagd_pkg::CH_W-1:0]    o_out_channel,
    output logic signed [vagd_pkg::PCM_W-1:0] o_pcm_sample,
    output logic                         o_last_of_byte
);
    import vagd_pkg::*;

    localparam int IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int HENT_W = 2 * HIST_W;

    // State memories and their valid bits
    logic [HENT_W-1:0]        hist_mem [CHANNEL_COUNT];
    logic [PRM_W-1:0]         prm_mem  [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_hist_vld;
    logic [CHANNEL_COUNT-1:0] r_prm_vld;

    // Read stage
    logic              r_r_valid;
    logic [CH_W-1:0]   r_r_ch;
    logic [POS_W-1:0]  r_r_pos;
    logic [BYTE_W-1:0] r_r_val;
    logic [HENT_W-1:0] r_hist;
    logic [PRM_W-1:0]  r_prm;

    // Execute stage
    logic               r_x_valid;
    logic               r_x_phase;
    logic [CH_W-1:0]    r_x_ch;
    logic [BYTE_W-1:0]  r_x_byte;
    t_hist              r_x_p1;
    t_hist              r_x_p2;
    logic [SHIFT_W-1:0] r_x_shift;
    logic [FILT_W-1:0]  r_x_filter;

    // Output register
    logic            r_o_valid;
    logic [CH_W-1:0] r_o_ch;
    t_pcm            r_o_pcm;
    logic            r_o_last;

    logic [IDX_W-1:0]  in_idx;
    logic [IDX_W-1:0]  r_idx;
    logic              ch_ok;
    logic              in_accept;
    logic              r_load;
    logic              r_is_sample;
    logic              r_go;
    logic              out_ready;
    logic              x_fire;
    logic              x_done;
    logic              hist_we;
    logic [IDX_W-1:0]  hist_widx;
    logic [HENT_W-1:0] hist_wdata;
    logic [HENT_W-1:0] hist_eff;
    logic              prm_we;
    logic [PRM_W-1:0]  prm_wdata;
    logic [NIB_W-1:0]  filt_code;
    logic [FILT_W-1:0] filt_map;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    assign in_idx    = IDX_W'(i_channel);
    assign r_idx     = IDX_W'(r_r_ch);
    assign ch_ok     = ({{(32-CH_W){1'b0}}, i_channel} < 32'(CHANNEL_COUNT));
    assign in_accept = i_in_valid && !o_in_stall;
    assign r_load    = in_accept && ch_ok && (i_byte_position != POS_FLAGS);

    assign r_is_sample = (r_r_pos != POS_HEADER);
    assign out_ready   = !r_o_valid || !i_out_stall;
    assign x_fire      = r_x_valid && out_ready;
    assign x_done      = x_fire && r_x_phase;
    // Headers leave at once; sample bytes wait for the execute stage to free up.
    assign r_go        = r_r_valid && (!r_is_sample || !r_x_valid || x_done);
    assign o_in_stall  = r_r_valid && !r_go;

    assign hist_we    = x_done;
    assign hist_widx  = IDX_W'(r_x_ch);
    assign hist_wdata = {alu_rsp.sum, r_x_p1};
    // Forward a write-back of the same channel into a byte leaving the read stage.
    assign hist_eff   = (hist_we && (hist_widx == r_idx)) ? hist_wdata : r_hist;

    assign filt_code = r_r_val[BYTE_W-1:NIB_W];
    assign filt_map  = (filt_code > FILTER_MAX) ? FILT_NONE : filt_code[FILT_W-1:0];
    assign prm_we    = r_go && !r_is_sample;
    assign prm_wdata = {r_r_val[SHIFT_W-1:0], filt_map};

    always_comb begin
        alu_req.p1     = r_x_p1;
        alu_req.p2     = r_x_p2;
        alu_req.shift  = r_x_shift;
        alu_req.filter = r_x_filter;
        alu_req.nibble = r_x_phase ? r_x_byte[BYTE_W-1:NIB_W] : r_x_byte[NIB_W-1:0];
    end

    vagd_predictor u_predictor (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // History memory: one write port, one registered read port with forwarding.
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_widx] <= hist_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            if (hist_we && (hist_widx == in_idx)) begin
                r_hist <= hist_wdata;
            end else begin
                r_hist <= r_hist_vld[in_idx] ? hist_mem[in_idx] : '0;
            end
        end else if (hist_we && (hist_widx == r_idx)) begin
            r_hist <= hist_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (hist_we) begin
            r_hist_vld[hist_widx] <= 1'b1;
        end
    end

    // Shift/filter memory, written by header bytes only.
    always_ff @(posedge i_clk) begin
        if (prm_we) begin
            prm_mem[r_idx] <= prm_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            if (prm_we && (r_idx == in_idx)) begin
                r_prm <= prm_wdata;
            end else begin
                r_prm <= r_prm_vld[in_idx] ? prm_mem[in_idx] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prm_vld <= '0;
        end else if (prm_we) begin
            r_prm_vld[r_idx] <= 1'b1;
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (r_load) begin
            r_r_valid <= 1'b1;
        end else if (r_go) begin
            r_r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_r_ch  <= i_channel;
            r_r_pos <= i_byte_position;
            r_r_val <= i_byte_value;
        end
    end

    // Execute stage: low nibble, then high nibble together with the write back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_x_phase <= 1'b0;
        end else if (r_go && r_is_sample) begin
            r_x_valid <= 1'b1;
            r_x_phase <= 1'b0;
        end else if (x_done) begin
            r_x_valid <= 1'b0;
            r_x_phase <= 1'b0;
        end else if (x_fire) begin
            r_x_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_go && r_is_sample) begin
            r_x_ch     <= r_r_ch;
            r_x_byte   <= r_r_val;
            r_x_p1     <= hist_eff[HENT_W-1:HIST_W];
            r_x_p2     <= hist_eff[HIST_W-1:0];
            r_x_shift  <= r_prm[PRM_W-1:FILT_W];
            r_x_filter <= r_prm[FILT_W-1:0];
        end else if (x_fire && !r_x_phase) begin
            r_x_p2 <= r_x_p1;
            r_x_p1 <= alu_rsp.sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fire) begin
            r_o_ch   <= r_x_ch;
            r_o_pcm  <= alu_rsp.pcm;
            r_o_last <= r_x_phase;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_channel  = r_o_ch;
    assign o_pcm_sample   = r_o_pcm;
    assign o_last_of_byte = r_o_last;

`ifndef NO_ASSERTIONS
    a_high_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_fire && r_x_phase) |=> (o_out_valid && o_last_of_byte))
        else $error("high-nibble beat not presented after second sample");

    a_x_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_go && r_is_sample) |-> (!r_x_valid || x_done))
        else $error("sample byte loaded over a busy execute stage");

    a_hist_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_we |=> r_hist_vld[$past(hist_widx)])
        else $error("history write-back left entry invalid");

    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_x_valid |-> !r_x_phase)
        else $error("execute phase set without an item");
`endif

endmodule
